// ----- src/tbpf_pkg.sv -----
package tbpf_pkg;

  // Video memory geometry: two byte banks split on address bit 0
  localparam int unsigned VramAw = 13;
  localparam int unsigned BankAw = VramAw - 1;
  localparam int unsigned BankDepth = 1 << BankAw;

  // Configuration register indexes
  localparam logic [1:0] CfgScrollX    = 2'd0;
  localparam logic [1:0] CfgScrollY    = 2'd1;
  localparam logic [1:0] CfgMapSelect  = 2'd2;
  localparam logic [1:0] CfgDataSelect = 2'd3;

  // Item kinds
  localparam logic ActWrite = 1'b0;
  localparam logic ActFetch = 1'b1;

  // Upper bits of the tile map base (0x1800 / 0x1C00)
  localparam logic [1:0] MapBaseTop = 2'b11;

  typedef enum logic [1:0] {
    FsIdle,
    FsMap,
    FsTile
  } fetch_state_e;

endpackage

// ----- src/tile_background_pixel_fetch.sv -----
// Tiled background pixel fetch, 2 bits per pixel. A write item (action 0)
// stores one byte into the 8 KiB video memory when it is taken. A fetch
// item (action 1) whose column lies on screen returns one pixel; a fetch at
// or beyond SCREEN_WIDTH returns nothing. A fetch holds busy high for one
// cycle after it is taken, as the tile map read feeds the tile data read
// through the same memory read ports; the next item may be taken while the
// tile data is read. The result is registered after the tile map read and
// the tile data read and appears on the result ports with result_valid_o
// high for exactly one cycle; the receiver cannot hold it off and must take
// it then. Video memory is two byte-wide banks (even and odd addresses), so
// both bit-planes of a tile row come back in one read. Memory is not cleared
// by reset: reading an entry never written gives an undefined colour.
// Configuration writes are always accepted (cfg_ready_o stays high) and must
// only be issued while no fetch is in flight.
module tile_background_pixel_fetch
  import tbpf_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [12:0] vram_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  screen_x_i,
  input  logic [7:0]  line_y_i,
  // result channel
  output logic        result_valid_o,
  output logic [7:0]  pixel_x_o,
  output logic [7:0]  pixel_y_o,
  output logic [1:0]  color_index_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam logic [8:0] ScreenW = 9'(SCREEN_WIDTH);

  // configuration registers
  logic [7:0] scroll_x_q, scroll_y_q;
  logic       map_select_q, data_select_q;

  // control
  fetch_state_e state_q, state_d;
  logic         accept;
  logic         accept_write, accept_fetch;
  logic         result_valid_q, result_valid_d;

  // fetch context
  logic [7:0] bx, by;
  logic [7:0] px_q, py_q;
  logic [3:0] bx_low_q;
  logic [2:0] by_low_q;

  // memory access
  logic [BankAw-1:0] map_index;
  logic [BankAw-1:0] row_index;
  logic [BankAw-1:0] rd_index;
  logic [BankAw-1:0] wr_index;
  logic              we_even, we_odd;
  logic [7:0]        even_rd_q, odd_rd_q;
  logic [7:0]        tile_num;
  logic [8:0]        tile_sel;
  logic [1:0]        color;

  // result registers
  logic [7:0] res_x_q, res_y_q;
  logic [1:0] res_c_q;

  logic [7:0] even_mem [BankDepth];
  logic [7:0] odd_mem  [BankDepth];

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q    <= '0;
      scroll_y_q    <= '0;
      map_select_q  <= 1'b0;
      data_select_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgScrollX:    scroll_x_q    <= cfg_data_i;
        CfgScrollY:    scroll_y_q    <= cfg_data_i;
        CfgMapSelect:  map_select_q  <= cfg_data_i[0];
        CfgDataSelect: data_select_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accept and classify an item beat
  assign accept       = start && !busy;
  assign accept_write = accept && (action_i == ActWrite);
  assign accept_fetch = accept && (action_i == ActFetch) && ({1'b0, screen_x_i} < ScreenW);

  // Background point and tile map address
  assign bx        = screen_x_i + scroll_x_q;
  assign by        = line_y_i + scroll_y_q;
  assign map_index = {MapBaseTop, map_select_q, by[7:3], bx[7:4]};

  // Tile number from the bank chosen by map column bit 0
  assign tile_num = bx_low_q[3] ? odd_rd_q : even_rd_q;
  // Signed mode: tile block 0x1000 for 0..127, 0x0800 for -128..-1
  assign tile_sel  = data_select_q ? {1'b0, tile_num} : {~tile_num[7], tile_num};
  assign row_index = {tile_sel, by_low_q};

  // Pick the pixel bit from both planes
  assign color = {odd_rd_q[~bx_low_q[2:0]], even_rd_q[~bx_low_q[2:0]]};

  // Memory port addressing
  assign rd_index = (state_q == FsMap) ? row_index : map_index;
  assign wr_index = vram_addr_i[VramAw-1:1];
  assign we_even  = accept_write && !vram_addr_i[0];
  assign we_odd   = accept_write && vram_addr_i[0];

  // Even byte bank
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      even_mem[wr_index] <= write_data_i;
    end
    even_rd_q <= even_mem[rd_index];
  end

  // Odd byte bank
  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      odd_mem[wr_index] <= write_data_i;
    end
    odd_rd_q <= odd_mem[rd_index];
  end

  // Hold fetch context
  always_ff @(posedge clk_i) begin
    if (accept_fetch) begin
      px_q     <= screen_x_i;
      py_q     <= line_y_i;
      bx_low_q <= bx[3:0];
      by_low_q <= by[2:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d        = state_q;
    result_valid_d = 1'b0;
    busy           = 1'b0;
    case (state_q)
      FsIdle: begin
        if (accept_fetch) state_d = FsMap;
      end
      FsMap: begin
        busy    = 1'b1;
        state_d = FsTile;
      end
      FsTile: begin
        result_valid_d = 1'b1;
        state_d        = accept_fetch ? FsMap : FsIdle;
      end
      default: state_d = FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= FsIdle;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (state_q == FsTile) begin
      res_x_q <= px_q;
      res_y_q <= py_q;
      res_c_q <= color;
    end
  end

  assign result_valid_o = result_valid_q;
  assign pixel_x_o      = res_x_q;
  assign pixel_y_o      = res_y_q;
  assign color_index_o  = res_c_q;

  // Checks
  a_map_then_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FsMap |=> state_q == FsTile)
    else $error("map read not followed by tile read");

  a_fetch_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_fetch |=> state_q == FsMap)
    else $error("accepted fetch did not start map read");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(state_q == FsTile))
    else $error("result without tile read");

  a_result_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> ({1'b0, res_x_q} < ScreenW))
    else $error("result column off screen");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FsMap |-> !(we_even || we_odd))
    else $error("memory write during fetch");

endmodule
